@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the recogniser's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ rtl/core/nwr_pkg.sv @@
`default_nettype none

package nwr_pkg;

	localparam int FUNC_W     = 2;
	localparam int STATE_ID_W = 5;
	localparam int LETTER_W   = 8;
	localparam int SET_W      = 32;
	localparam int CFG_IDX_W  = 1;

	// Item function codes.
	localparam logic [FUNC_W-1:0] FUNC_ADD_TRANS  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LETTER     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EMPTY_WORD = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK   = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0]     func;
		logic [STATE_ID_W-1:0] origin_state;
		logic [LETTER_W-1:0]   letter;
		logic [STATE_ID_W-1:0] target_state;
		logic                  word_end;
	} nwr_item_t;

	typedef struct packed {
		logic [SET_W-1:0] reached_set;
		logic             accepted;
		logic             word_done;
	} nwr_result_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP
	} nwr_state_t;

	typedef struct packed {
		logic mem_clear;
		logic mem_wr;
		logic mem_rd;
		logic latch_item;
		logic load_result;
	} nwr_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} nwr_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/nwr_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"

module nwr_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	input  wire logic [nwr_pkg::FUNC_W-1:0] item_func,
	output logic                           item_stall,
	input  wire nwr_pkg::nwr_sts_t         sts,
	output nwr_pkg::nwr_cmd_t              cmd
);
	import nwr_pkg::*;

	nwr_state_t state_q;
	nwr_state_t state_nxt;
	logic       accept;

	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept && (item_func == FUNC_LETTER || item_func == FUNC_EMPTY_WORD)) begin
					state_nxt = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		cmd        = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mem_clear = 1'b1;
			end
			S_IDLE: begin
				item_stall     = 1'b0;
				cmd.latch_item = accept;
				cmd.mem_wr     = accept && (item_func == FUNC_ADD_TRANS);
				cmd.mem_rd     = accept && (item_func == FUNC_LETTER);
			end
			S_LOOKUP: begin
				cmd.load_result = sts.out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// The sweep owns the banks: no lookup or transition write may overlap it.
	`ASSERT_IMPLY(a_clear_exclusive, clk, arst_n, cmd.mem_clear, !cmd.mem_wr && !cmd.mem_rd)
	// A lookup finishes as soon as the result register can take its result.
	`ASSERT_NEXT(a_lookup_ends, clk, arst_n, state_q == S_LOOKUP && sts.out_free, state_q == S_IDLE)
	// The sweep ends exactly once, straight into idle.
	`ASSERT_NEXT(a_clear_to_idle, clk, arst_n, state_q == S_CLEAR && sts.clear_last, state_q == S_IDLE)

endmodule

`default_nettype wire

@@ rtl/core/nwr_dpath.sv @@
`default_nettype none
`include "assert_macros.svh"

module nwr_dpath #(
	parameter int NUM_STATES  = 32,
	parameter int LETTER_BITS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire nwr_pkg::nwr_cmd_t            cmd,
	output nwr_pkg::nwr_sts_t                 sts,
	input  wire nwr_pkg::nwr_item_t           item,
	input  wire logic                         cfg_wr_en,
	input  wire logic [nwr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nwr_pkg::SET_W-1:0]     cfg_data,
	output nwr_pkg::nwr_result_t              result,
	output logic                              result_valid,
	input  wire logic                         result_stall
);
	import nwr_pkg::*;

	// States at or above SET_W can never be the target of a transition.
	localparam int SW          = (NUM_STATES < SET_W) ? NUM_STATES : SET_W;
	localparam int TW          = $clog2(SW);
	localparam int NUM_LETTERS = 1 << LETTER_BITS;

	logic [SW-1:0]          initial_q;
	logic [SW-1:0]          final_q;
	logic [SW-1:0]          active_q;
	logic                   at_start_q;
	logic [FUNC_W-1:0]      func_q;
	logic                   word_end_q;
	logic [LETTER_BITS-1:0] clr_q;
	nwr_result_t            result_q;
	logic                   result_valid_q;

	logic [LETTER_BITS-1:0] addr;
	logic [TW-1:0]          tgt_idx;
	logic                   tgt_ok;
	logic [SW-1:0]          row_s1 [SW];
	logic [SW-1:0]          cur_set;
	logic [SW-1:0]          next_set;
	logic [SW-1:0]          reached;
	logic                   done;

	assign addr    = item.letter[LETTER_BITS-1:0];
	assign tgt_idx = item.target_state[TW-1:0];
	assign tgt_ok  = int'(item.target_state) < SW;

	// One bank per origin state, addressed by letter.
	for (genvar b = 0; b < SW; b++) begin : g_bank
		logic [SW-1:0] mem [NUM_LETTERS];
		logic          wr_hit;

		assign wr_hit = cmd.mem_wr && tgt_ok && (item.origin_state == STATE_ID_W'(b));

		always_ff @(posedge clk) begin
			if (cmd.mem_clear) begin
				mem[clr_q] <= '0;
			end else if (wr_hit) begin
				mem[addr][tgt_idx] <= 1'b1;
			end
			if (cmd.mem_rd) begin
				row_s1[b] <= mem[addr];
			end
		end
	end

	always_comb begin
		cur_set  = at_start_q ? initial_q : active_q;
		next_set = '0;
		for (int b = 0; b < SW; b++) begin
			if (cur_set[b]) begin
				next_set = next_set | row_s1[b];
			end
		end
	end

	assign reached = (func_q == FUNC_LETTER) ? next_set : initial_q;
	assign done    = (func_q == FUNC_LETTER) ? word_end_q : 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			func_q     <= item.func;
			word_end_q <= item.word_end;
		end
		if (cmd.load_result) begin
			result_q.reached_set <= SET_W'(reached);
			result_q.accepted    <= |(reached & final_q);
			result_q.word_done   <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q      <= '0;
			final_q        <= '0;
			active_q       <= '0;
			at_start_q     <= 1'b1;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_INITIAL_MASK: initial_q <= cfg_data[SW-1:0];
					CFG_FINAL_MASK:   final_q   <= cfg_data[SW-1:0];
					default:          initial_q <= initial_q;
				endcase
			end
			if (cmd.mem_clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load_result && func_q == FUNC_LETTER) begin
				active_q   <= next_set;
				at_start_q <= word_end_q;
			end
			if (cmd.load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_last = &clr_q;
	assign sts.out_free   = !result_valid_q || !result_stall;
	assign result         = result_q;
	assign result_valid   = result_valid_q;

	// After a letter the stored active set is exactly what was reported.
	`ASSERT_NEXT(a_active_matches, clk, arst_n, cmd.load_result && func_q == FUNC_LETTER,
		SET_W'(active_q) == result_q.reached_set)
	// A new result is loaded only once the previous one has gone.
	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.load_result,
		!result_valid_q || !result_stall)

endmodule

`default_nettype wire

@@ rtl/core/nfa_word_recognizer.sv @@
`default_nettype none

// Bit-parallel recogniser for a nondeterministic finite automaton of up to NUM_STATES
// states over letters of LETTER_BITS bits. An add-transition transaction sets one
// target bit in the row for (origin, letter) and leaves the block ready for the next
// transaction. In a letter transaction the letter addresses one bank per origin
// state in parallel; the registered rows are then gated by the active set and ORed
// into the next set, which goes to the result register together with the accept
// flag (reached set meets the final mask) and the end-of-word flag. An empty-word
// check reports the initial mask without disturbing a word in progress. The result
// register lets a new transaction be taken while an earlier result still waits.
// After reset the banks are swept clear, one letter address per cycle over all
// 2**LETTER_BITS addresses (256 with the default), with item_stall held high;
// configuration writes are taken throughout and should otherwise only be made
// while the block is idle.
module nfa_word_recognizer #(
	parameter int NUM_STATES  = 32,
	parameter int LETTER_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input item channel.
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire nwr_pkg::nwr_item_t            item,
	// Result channel.
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output nwr_pkg::nwr_result_t               result,
	// Configuration write port.
	input  wire logic                          cfg_wr_en,
	input  wire logic [nwr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nwr_pkg::SET_W-1:0]     cfg_data
);
	import nwr_pkg::*;

	nwr_cmd_t cmd;
	nwr_sts_t sts;

	// The controller sequences the sweep, the transition writes and the lookups.
	nwr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_func  (item.func),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the banks, the masks, the active set and the result register.
	nwr_dpath #(
		.NUM_STATES  (NUM_STATES),
		.LETTER_BITS (LETTER_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire

@@ bench/nfa_word_recognizer_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the bit-parallel NFA recogniser. A short table of
// hand-written transactions comes first, then eight phases of random
// automata and words. Every accepted input transaction is run through a
// local model of the automaton, and every result transaction is compared
// field by field with the oldest prediction still waiting.
module nfa_word_recognizer_tb;

	import nwr_pkg::*;

	// The package names three function codes; the fourth is left unused and
	// must be ignored by the block.
	localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 240;
	// Allow a comfortable margin after the last result before touching the
	// masks or ending the run.
	localparam int SETTLE_CYCLES  = 8;
	// The clearing sweep after reset runs without a single handshake, so the
	// limit sits well above its length.
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic {
		ROW_ITEM,
		ROW_MASKS
	} row_kind_t;

	// One line of the directed table. Mask rows carry the initial mask in
	// mask_a and the final mask in mask_b. Item rows with known set carry the
	// result that can be read straight off the automaton; the others are left
	// to the model.
	typedef struct packed {
		row_kind_t   kind;
		nwr_item_t   it;
		logic [31:0] mask_a;
		logic [31:0] mask_b;
		logic        known;
		nwr_result_t want;
	} dir_row_t;

	localparam nwr_item_t   NO_ITEM   = '0;
	localparam nwr_result_t NO_RESULT = '0;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// Straight after reset both masks are zero: nothing is initial.
		'{ROW_ITEM, '{FUNC_EMPTY_WORD, 5'd0, 8'h00, 5'd0, 1'b0}, '0, '0, 1'b1,
			'{32'h0000_0000, 1'b0, 1'b1}},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'h00, 5'd0, 1'b1}, '0, '0, 1'b1,
			'{32'h0000_0000, 1'b0, 1'b1}},
		// State 0 is initial, state 31 accepting.
		'{ROW_MASKS, NO_ITEM, 32'h0000_0001, 32'h8000_0000, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_ADD_TRANS, 5'd0, 8'h00, 5'd31, 1'b0}, '0, '0, 1'b0, NO_RESULT},
		// The same transition a second time must change nothing.
		'{ROW_ITEM, '{FUNC_ADD_TRANS, 5'd0, 8'h00, 5'd31, 1'b1}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_ADD_TRANS, 5'd31, 8'hFF, 5'd0, 1'b0}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_ADD_TRANS, 5'd31, 8'hFF, 5'd31, 1'b0}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'h00, 5'd0, 1'b0}, '0, '0, 1'b1,
			'{32'h8000_0000, 1'b1, 1'b0}},
		// An empty-word check in mid-word must leave the word alone.
		'{ROW_ITEM, '{FUNC_EMPTY_WORD, 5'd31, 8'hFF, 5'd31, 1'b0}, '0, '0, 1'b1,
			'{32'h0000_0001, 1'b0, 1'b1}},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'hFF, 5'd0, 1'b1}, '0, '0, 1'b1,
			'{32'h8000_0001, 1'b1, 1'b1}},
		// The word has ended, so this letter starts again from state 0.
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'hFF, 5'd0, 1'b1}, '0, '0, 1'b1,
			'{32'h0000_0000, 1'b0, 1'b1}},
		// The unused function code with every field at its top value.
		'{ROW_ITEM, '{FUNC_RESERVED, 5'd31, 8'hFF, 5'd31, 1'b1}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'h00, 5'd0, 1'b0}, '0, '0, 1'b1,
			'{32'h8000_0000, 1'b1, 1'b0}},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'h00, 5'd0, 1'b1}, '0, '0, 1'b1,
			'{32'h0000_0000, 1'b0, 1'b1}},
		// Every state initial, nothing accepting.
		'{ROW_MASKS, NO_ITEM, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_EMPTY_WORD, 5'd0, 8'h00, 5'd0, 1'b0}, '0, '0, 1'b1,
			'{32'hFFFF_FFFF, 1'b0, 1'b1}},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'h00, 5'd0, 1'b1}, '0, '0, 1'b1,
			'{32'h8000_0000, 1'b0, 1'b1}},
		// Every state accepting, state 0 initial again.
		'{ROW_MASKS, NO_ITEM, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_ADD_TRANS, 5'd0, 8'h55, 5'd10, 1'b0}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_ADD_TRANS, 5'd10, 8'hAA, 5'd21, 1'b1}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd21, 8'h55, 5'd10, 1'b0}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd10, 8'hAA, 5'd21, 1'b0}, '0, '0, 1'b0, NO_RESULT},
		'{ROW_ITEM, '{FUNC_EMPTY_WORD, 5'd0, 8'h00, 5'd0, 1'b1}, '0, '0, 1'b1,
			'{32'h0000_0001, 1'b1, 1'b1}},
		'{ROW_ITEM, '{FUNC_LETTER, 5'd0, 8'hAA, 5'd0, 1'b1}, '0, '0, 1'b0, NO_RESULT}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	nwr_item_t            item_data;
	logic                 result_valid;
	logic                 result_stall;
	nwr_result_t          result_data;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SET_W-1:0]     cfg_data;

	// Local copy of the automaton: one row of target states per (origin,
	// letter) pair, the set of states currently live, and the two masks.
	logic [SET_W-1:0] trans_rows [0:(1 << (STATE_ID_W + LETTER_W)) - 1];
	logic [SET_W-1:0] live_set;
	logic             at_word_start;
	logic [SET_W-1:0] init_mask;
	logic [SET_W-1:0] fin_mask;

	nwr_result_t pending_results [$];

	int gap_pct;
	int stall_pct;
	int fail_count;
	int items_sent;
	int results_checked;
	int results_accepting;
	int words_closed;
	int quiet_cycles;

	nfa_word_recognizer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Steps the local automaton by one transaction. Returns 1 when the
	// transaction yields a result, which is then left in r.
	function automatic bit nfa_advance(input nwr_item_t it, output nwr_result_t r);
		logic [SET_W-1:0] from_set;
		logic [SET_W-1:0] to_set;
		r = '0;
		case (it.func)
			FUNC_ADD_TRANS: begin
				trans_rows[{it.origin_state, it.letter}][it.target_state] = 1'b1;
				return 1'b0;
			end
			FUNC_LETTER: begin
				// The initial mask is only consulted when a word begins.
				from_set = at_word_start ? init_mask : live_set;
				to_set = '0;
				for (int s = 0; s < SET_W; s++) begin
					if (from_set[s])
						to_set |= trans_rows[{5'(s), it.letter}];
				end
				live_set = to_set;
				at_word_start = it.word_end;
				if (it.word_end)
					words_closed++;
				r.reached_set = to_set;
				r.accepted = |(to_set & fin_mask);
				r.word_done = it.word_end;
				return 1'b1;
			end
			FUNC_EMPTY_WORD: begin
				r.reached_set = init_mask;
				r.accepted = |(init_mask & fin_mask);
				r.word_done = 1'b1;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Offers one transaction after a random number of idle cycles and holds
	// it until the block takes it. Valid is left high on return so that a
	// following transaction can go out on the very next edge.
	task automatic send_item(input nwr_item_t it, input bit known, input nwr_result_t want);
		nwr_result_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do
			@(posedge clk);
		while (item_stall);
		if (nfa_advance(it, predicted))
			pending_results.push_back(known ? want : predicted);
		if (it.func != FUNC_RESERVED)
			items_sent++;
	endtask

	// Brings the block to rest: no transaction on offer, every prediction
	// met, and a settling wait on top in case an add-transition is still in
	// the pipeline, since that leaves no result to wait for.
	task automatic wait_quiet();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_masks(input logic [SET_W-1:0] init_val, input logic [SET_W-1:0] fin_val);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_INITIAL_MASK;
		cfg_data <= init_val;
		@(posedge clk);
		init_mask = init_val;
		cfg_index <= CFG_FINAL_MASK;
		cfg_data <= fin_val;
		@(posedge clk);
		fin_mask = fin_val;
		cfg_wr_en <= 1'b0;
	endtask

	// Mask choices per phase: the two extremes, a sparse random set, a single
	// state, and a fully random set.
	function automatic logic [SET_W-1:0] pick_mask(input int sel);
		case (sel)
			0: return '0;
			1: return '1;
			2: return $urandom & $urandom & $urandom;
			3: return 32'h1 << $urandom_range(SET_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// A result transaction is compared with the oldest prediction. The stall
	// for the next edge is drawn afterwards, so the handshake above always
	// sees the value that the block saw.
	always @(posedge clk) begin
		nwr_result_t want;
		if (result_valid && !result_stall) begin
			results_checked++;
			if (result_data.accepted)
				results_accepting++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: set %h acc %b done %b", $time,
					result_data.reached_set, result_data.accepted, result_data.word_done);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_data.reached_set !== want.reached_set) begin
					$display("%0t: reached_set expected %h, got %h", $time,
						want.reached_set, result_data.reached_set);
					fail_count++;
				end
				if (result_data.accepted !== want.accepted) begin
					$display("%0t: accepted expected %b, got %b", $time,
						want.accepted, result_data.accepted);
					fail_count++;
				end
				if (result_data.word_done !== want.word_done) begin
					$display("%0t: word_done expected %b, got %b", $time,
						want.word_done, result_data.word_done);
					fail_count++;
				end
			end
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Ends the run if neither channel completes a transaction for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("nfa_word_recognizer regression: fail");
		$finish;
	end

	initial begin
		logic [7:0]  alphabet [6];
		logic [31:0] rnd;
		nwr_item_t   it;
		int          budget;
		int          word_len;
		bit          leave_open;

		item_valid <= 1'b0;
		item_data <= '0;
		result_stall <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_INITIAL_MASK;
		cfg_data <= '0;
		arst_n <= 1'b0;
		for (int k = 0; k < $size(trans_rows); k++)
			trans_rows[k] = '0;
		live_set = '0;
		at_word_start = 1'b1;
		init_mask = '0;
		fin_mask = '0;
		gap_pct = 0;
		stall_pct = 0;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		results_accepting = 0;
		words_closed = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The first transaction simply waits out the clearing
		// sweep, as item_stall stays high until the banks are clear.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_MASKS) begin
				wait_quiet();
				write_masks(DIRECTED[r].mask_a, DIRECTED[r].mask_b);
			end else begin
				send_item(DIRECTED[r].it, DIRECTED[r].known, DIRECTED[r].want);
			end
		end

		// Random part. Each phase settles the block, writes fresh masks, picks a
		// small alphabet so that rows fill up and words travel deep into the
		// automaton, and chooses how the two sides hold back. The store is never
		// cleared, so later phases run over an ever denser automaton.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_quiet();
			case (ph)
				0: write_masks(pick_mask(2), pick_mask(4));
				1: write_masks(pick_mask(1), pick_mask(0));
				2: write_masks(pick_mask(3), pick_mask(1));
				3: write_masks(pick_mask(2), pick_mask(2));
				4: write_masks(pick_mask(0), pick_mask(4));
				5: write_masks(pick_mask(2), pick_mask(1));
				6: write_masks(pick_mask(3), pick_mask(4));
				default: write_masks(pick_mask(4), pick_mask(2));
			endcase
			case (ph % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 48;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 48;
				end
				default: begin
					gap_pct = 7;
					stall_pct = 7;
				end
			endcase
			for (int k = 0; k < 6; k++)
				alphabet[k] = 8'($urandom);
			if (ph == 0) begin
				alphabet[0] = 8'h00;
				alphabet[5] = 8'hFF;
			end

			budget = items_sent + PHASE_ITEMS;
			while (items_sent < budget) begin
				if ($urandom_range(99) < 12) begin
					// Noise: any field pattern, with the function chosen so that
					// every code turns up, the unused one included.
					rnd = $urandom;
					it = rnd[$bits(nwr_item_t)-1:0];
					case ($urandom_range(3))
						0: it.func = FUNC_RESERVED;
						1: it.func = FUNC_EMPTY_WORD;
						2: it.func = FUNC_LETTER;
						default: it.func = FUNC_ADD_TRANS;
					endcase
					send_item(it, 1'b0, NO_RESULT);
				end else begin
					// A well-formed word, often preceded by a few new transitions
					// over the phase's alphabet.
					if ($urandom_range(1)) begin
						repeat ($urandom_range(1, 3)) begin
							rnd = $urandom;
							it = rnd[$bits(nwr_item_t)-1:0];
							it.func = FUNC_ADD_TRANS;
							it.letter = alphabet[$urandom_range(5)];
							send_item(it, 1'b0, NO_RESULT);
						end
					end
					word_len = $urandom_range(1, 6);
					// Now and then a word is left open, so the next one carries
					// on from wherever this one stopped.
					leave_open = ($urandom_range(99) < 8);
					for (int w = 0; w < word_len; w++) begin
						rnd = $urandom;
						it = rnd[$bits(nwr_item_t)-1:0];
						if ($urandom_range(99) < 5) begin
							it.func = FUNC_EMPTY_WORD;
							send_item(it, 1'b0, NO_RESULT);
						end
						it.func = FUNC_LETTER;
						it.letter = alphabet[$urandom_range(5)];
						it.word_end = (w == word_len - 1) && !leave_open;
						send_item(it, 1'b0, NO_RESULT);
					end
				end
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d transactions over %0d random phases; %0d words were closed.",
			items_sent, NUM_PHASES, words_closed);
		$display("Checked %0d results, %0d of them accepting.",
			results_checked, results_accepting);
		if (fail_count == 0) begin
			$display("nfa_word_recognizer regression: pass");
		end else begin
			$display("nfa_word_recognizer regression: fail");
		end
		$finish;
	end

endmodule
